/* sv/krtu_pkg.sv */
// Shared types, constants and helpers for the keyed roster table.
package krtu_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int KEY_W = 128;
    localparam int ENTRY_W = 256;
    localparam int SLOT_W = 4;

    typedef enum logic [1:0] {
        CMD_UPSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_OTHER  = 2'd2,
        CMD_SPARE  = 2'd3
    } krtu_cmd_t;

    typedef enum logic [2:0] {
        TS_UPDATED  = 3'd0,
        TS_INSERTED = 3'd1,
        TS_FULL     = 3'd2,
        TS_REMOVED  = 3'd3,
        TS_MISS     = 3'd4,
        TS_IGNORED  = 3'd5
    } krtu_tstat_t;

    typedef enum logic [1:0] {
        SEQ_IN_ORDER  = 2'd0,
        SEQ_GAP       = 2'd1,
        SEQ_BACKWARDS = 2'd2
    } krtu_sstat_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] seq_num;
    } krtu_in_t;

    typedef struct packed {
        logic [3:0]  slot;
        logic [2:0]  table_status;
        logic [1:0]  seq_status;
        logic [31:0] seq_skipped;
    } krtu_out_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] skipped;
    } krtu_seq_res_t;

    // Slot index as reported on the result, masked to the field width.
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

/* sv/krtu_ram.sv */
// Simple dual-port synchronous RAM with a registered read port.
module krtu_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 256,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/krtu_seq_check.sv */
// Sequence number tracker: compares each number with the last one stored.
module krtu_seq_check (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   upd,
    input  logic [31:0]            seq_num,
    output krtu_pkg::krtu_seq_res_t res
);

    logic [31:0] last_seq_reg;
    logic [31:0] diff_up;
    logic [31:0] diff_down;

    assign diff_up   = seq_num - last_seq_reg;
    assign diff_down = last_seq_reg - seq_num;

    always_comb begin
        res.status  = krtu_pkg::SEQ_IN_ORDER;
        res.skipped = 32'd0;
        if (seq_num > last_seq_reg) begin
            if (diff_up > 32'd1) begin
                res.status  = krtu_pkg::SEQ_GAP;
                res.skipped = diff_up - 32'd1;
            end
        end else if (seq_num < last_seq_reg) begin
            res.status  = krtu_pkg::SEQ_BACKWARDS;
            res.skipped = diff_down;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_seq_reg <= 32'd0;
        end else if (upd) begin
            last_seq_reg <= seq_num;
        end
    end

endmodule

/* sv/keyed_roster_table_update.sv */
// Keyed roster table: upsert and remove by 128-bit key, with a sequence check.
// An ignored item skips the scan; upsert and remove scan the key RAM one entry per
// cycle (an upsert stops at its first key match), and the result is registered once
// the result register is free. A new item is taken only once the last result is
// committed, as the input is ready only while idle.
// Reset clears every valid bit, the last sequence number and the result valid flag;
// the entry RAM is not cleared, since only entries marked valid are ever compared.
module keyed_roster_table_update (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  krtu_pkg::krtu_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output krtu_pkg::krtu_out_t m_data
);

    localparam logic [krtu_pkg::IDX_W-1:0] LAST_IDX =
        krtu_pkg::IDX_W'(krtu_pkg::TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                              state_reg, state_next;
    logic [krtu_pkg::IDX_W-1:0]          cnt_reg, cnt_next;
    krtu_pkg::krtu_in_t                  item_reg, item_next;
    logic                                found_reg, found_next;
    logic                                free_ok_reg, free_ok_next;
    logic [krtu_pkg::IDX_W-1:0]          free_idx_reg, free_idx_next;
    logic [krtu_pkg::IDX_W-1:0]          hit_idx_reg, hit_idx_next;
    logic [krtu_pkg::TABLE_ENTRIES-1:0]  valid_reg, valid_next;
    logic                                m_valid_reg, m_valid_next;
    krtu_pkg::krtu_out_t                 out_reg, out_next;

    // Entry RAM port signals. An entry packs velocity, position and key.
    logic                                ram_we;
    logic [krtu_pkg::IDX_W-1:0]          ram_waddr;
    logic [krtu_pkg::ENTRY_W-1:0]        ram_wdata;
    logic [krtu_pkg::IDX_W-1:0]          ram_raddr;
    logic [krtu_pkg::ENTRY_W-1:0]        ram_rdata;

    logic                                key_hit;
    logic                                seq_upd;
    krtu_pkg::krtu_seq_res_t             seq_res;

    krtu_ram #(
        .DEPTH (krtu_pkg::TABLE_ENTRIES),
        .WIDTH (krtu_pkg::ENTRY_W),
        .AW    (krtu_pkg::IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    krtu_seq_check u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (seq_upd),
        .seq_num (item_reg.seq_num),
        .res     (seq_res)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // The key read back this cycle belongs to the entry at cnt_reg.
    assign key_hit = valid_reg[cnt_reg] &&
                     (ram_rdata[krtu_pkg::KEY_W-1:0] == {item_reg.key_high, item_reg.key_low});

    assign ram_wdata = {item_reg.vel_y, item_reg.vel_x, item_reg.pos_y, item_reg.pos_x,
                        item_reg.key_high, item_reg.key_low};

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        item_next     = item_reg;
        found_next    = found_reg;
        free_ok_next  = free_ok_reg;
        free_idx_next = free_idx_reg;
        hit_idx_next  = hit_idx_reg;
        valid_next    = valid_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_next      = out_reg;
        ram_we        = 1'b0;
        ram_waddr     = found_reg ? hit_idx_reg : free_idx_reg;
        ram_raddr     = '0;
        seq_upd       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                // Entry zero is read on acceptance so the scan starts next cycle.
                if (s_valid) begin
                    item_next     = s_data;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    free_ok_next  = 1'b0;
                    free_idx_next = '0;
                    hit_idx_next  = '0;
                    if (s_data.cmd == krtu_pkg::CMD_UPSERT ||
                        s_data.cmd == krtu_pkg::CMD_REMOVE) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN: begin
                // Read the next entry while comparing the current one.
                ram_raddr = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (item_reg.cmd == krtu_pkg::CMD_UPSERT) begin
                    if (key_hit) begin
                        found_next   = 1'b1;
                        hit_idx_next = cnt_reg;
                        state_next   = ST_FINISH;
                    end else begin
                        if (!valid_reg[cnt_reg] && !free_ok_reg) begin
                            free_ok_next  = 1'b1;
                            free_idx_next = cnt_reg;
                        end
                        if (cnt_reg == LAST_IDX) begin
                            state_next = ST_FINISH;
                        end
                    end
                end else begin
                    // Remove clears every match; the lowest one is reported.
                    if (key_hit) begin
                        valid_next[cnt_reg] = 1'b0;
                        if (!found_reg) begin
                            found_next   = 1'b1;
                            hit_idx_next = cnt_reg;
                        end
                    end
                    if (cnt_reg == LAST_IDX) begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH: begin
                // Commit only once the result register is free.
                if (!m_valid_reg || m_ready) begin
                    seq_upd               = 1'b1;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                    out_next.seq_status   = seq_res.status;
                    out_next.seq_skipped  = seq_res.skipped;
                    out_next.slot         = '0;
                    out_next.table_status = krtu_pkg::TS_IGNORED;
                    if (item_reg.cmd == krtu_pkg::CMD_UPSERT) begin
                        if (found_reg || free_ok_reg) begin
                            ram_we                = 1'b1;
                            valid_next[ram_waddr] = 1'b1;
                            out_next.slot         = krtu_pkg::to_slot(ram_waddr);
                            out_next.table_status = found_reg ? krtu_pkg::TS_UPDATED
                                                              : krtu_pkg::TS_INSERTED;
                        end else begin
                            out_next.table_status = krtu_pkg::TS_FULL;
                        end
                    end else if (item_reg.cmd == krtu_pkg::CMD_REMOVE) begin
                        if (found_reg) begin
                            out_next.slot         = krtu_pkg::to_slot(hit_idx_reg);
                            out_next.table_status = krtu_pkg::TS_REMOVED;
                        end else begin
                            out_next.table_status = krtu_pkg::TS_MISS;
                        end
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg      <= cnt_next;
        item_reg     <= item_next;
        found_reg    <= found_next;
        free_ok_reg  <= free_ok_next;
        free_idx_reg <= free_idx_next;
        hit_idx_reg  <= hit_idx_next;
        out_reg      <= out_next;
    end

endmodule

/* sv/krtu_checker.sv */
// Port-level checker for the keyed roster table, bound to the top level.
module krtu_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input krtu_pkg::krtu_out_t m_data
);

    // One item at a time: acceptance closes the input until the item is done.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again while an item is in flight");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result beat changed or dropped");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.table_status <= krtu_pkg::TS_IGNORED &&
                     m_data.seq_status <= krtu_pkg::SEQ_BACKWARDS))
        else $error("result beat carries an undefined status code");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.table_status == krtu_pkg::TS_FULL ||
                     m_data.table_status == krtu_pkg::TS_MISS ||
                     m_data.table_status == krtu_pkg::TS_IGNORED)) |-> (m_data.slot == 4'd0))
        else $error("slot is nonzero although no entry changed");

    a_in_order_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.seq_status == krtu_pkg::SEQ_IN_ORDER) |->
            (m_data.seq_skipped == 32'd0))
        else $error("in-order sequence reports skipped numbers");

endmodule

bind keyed_roster_table_update krtu_checker u_krtu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
